// ----- hw/rtl/ltpc_pkg.sv -----
// shared types and constants for the line transparency packet checker
`timescale 1ns / 1ps

package ltpc_pkg;

  // line ends once it holds this many bytes minus one
  localparam int unsigned LineLimit = 200;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChNl      = 8'h0a;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChA       = 8'h41;
  localparam logic [7:0] ChB       = 8'h42;
  localparam logic [7:0] Mask7     = 8'h7f;
  localparam logic [7:0] Mask8     = 8'hff;
  localparam logic [2:0] ZeroAbort = 3'd5;
  localparam logic [9:0] NumSat    = 10'd1023;

  // byte strings with the first character in the lowest byte
  localparam logic [31:0] HeadTen   = 32'h4120_3031; // "10 A"
  localparam logic [31:0] HeadDone  = 32'h656e_6f64; // "done"
  localparam logic [39:0] HeadRdone = 40'h65_6e6f_6472; // "rdone"

  typedef enum logic [2:0] {
    EV_VALID     = 3'd0,
    EV_IGNORED   = 3'd1,
    EV_INVALID   = 3'd2,
    EV_REMOTE    = 3'd3,
    EV_LOCAL     = 3'd4,
    EV_ABORT     = 3'd5,
    EV_MAP_READ  = 3'd6
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] code;
  } ev_t;

endpackage

// ----- hw/rtl/ltpc_front.sv -----
// front end: line assembly, abort detection and line classification
`timescale 1ns / 1ps

module ltpc_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         command_i,
  input  logic [7:0]   data_byte_i,
  output logic         push_o,
  output ltpc_pkg::ev_t push_ev_o,
  input  logic         full_i
);
  import ltpc_pkg::*;

  logic        seven_q;
  logic        halted_q, halted_d;
  logic [7:0]  len_q, len_d;
  logic [2:0]  zrun_q, zrun_d;
  logic [9:0]  num_q, num_d;
  logic        dig_q, dig_d;
  logic [47:0] head_q, head_d;
  logic [31:0] aft_q, aft_d;
  logic [2:0]  acnt_q, acnt_d;

  logic        accept;
  logic [7:0]  ch;
  logic [2:0]  zrun_n;
  logic        abort, is_nl, keep_nl, do_store, finish;
  logic [13:0] num_mul;
  logic [7:0]  len_s, len_n;
  logic [9:0]  num_s, num_n;
  logic        dig_s, dig_n;
  logic [47:0] head_s, head_n;
  logic [31:0] aft_s, aft_n;
  logic [2:0]  acnt_s, acnt_n;
  logic [7:0]  cmask;
  logic        shape, big;
  ev_t         line_ev;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    ch      = seven_q ? (data_byte_i & Mask7) : data_byte_i;
    zrun_n  = (ch == ChZero) ? zrun_q + 3'd1 : 3'd0;
    abort   = (zrun_n >= ZeroAbort);
    is_nl   = (ch == ChNl);
    keep_nl = is_nl && (len_q == 8'd4) && (head_q[31:0] == HeadTen);
    do_store = !is_nl || keep_nl;
    finish  = (is_nl && !keep_nl) ||
              (!is_nl && ({1'b0, len_q} >= 9'(LineLimit - 2)));

    // line contents with this byte appended
    head_s = head_q;
    if (len_q < 8'd6) begin
      head_s[{len_q[2:0], 3'b000} +: 8] = ch;
    end
    num_mul = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0} + {10'd0, ch[3:0]};
    num_s   = num_q;
    dig_s   = dig_q;
    aft_s   = aft_q;
    acnt_s  = acnt_q;
    if (!dig_q && ch >= ChZero && ch <= ChNine) begin
      num_s = (num_mul > {4'd0, NumSat}) ? NumSat : num_mul[9:0];
    end else begin
      dig_s = 1'b1;
      if (acnt_q < 3'd4) begin
        aft_s[{acnt_q[1:0], 3'b000} +: 8] = ch;
        acnt_s = acnt_q + 3'd1;
      end
    end
    len_s = len_q + 8'd1;

    // the line as it stands when it ends here
    len_n  = do_store ? len_s  : len_q;
    num_n  = do_store ? num_s  : num_q;
    dig_n  = do_store ? dig_s  : dig_q;
    head_n = do_store ? head_s : head_q;
    aft_n  = do_store ? aft_s  : aft_q;
    acnt_n = do_store ? acnt_s : acnt_q;

    cmask = seven_q ? Mask7 : Mask8;
    big   = (num_n[9:8] != 2'b00);
    shape = (aft_n[7:0] == ChSpace) && (aft_n[15:8] == ChA) &&
            (aft_n[23:16] == (cmask & num_n[7:0])) && (aft_n[31:24] == ChB);

    line_ev.code = 8'd0;
    priority if (head_n[31:0] == HeadDone && head_n[39:32] == 8'd0) begin
      line_ev.kind = EV_REMOTE;
    end else if (head_n[39:0] == HeadRdone && head_n[47:40] == 8'd0) begin
      line_ev.kind = EV_LOCAL;
    end else begin
      line_ev.code = big ? 8'd0 : num_n[7:0];
      priority if (!shape || big) begin
        line_ev.kind = EV_INVALID;
      end else if (aft_n[23:16] == num_n[7:0]) begin
        line_ev.kind = EV_VALID;
      end else begin
        line_ev.kind = EV_IGNORED;
      end
    end
  end

  always_comb begin
    push_o         = 1'b0;
    push_ev_o.kind = EV_MAP_READ;
    push_ev_o.code = data_byte_i;
    halted_d = halted_q;
    len_d    = len_q;
    zrun_d   = zrun_q;
    num_d    = num_q;
    dig_d    = dig_q;
    head_d   = head_q;
    aft_d    = aft_q;
    acnt_d   = acnt_q;
    if (accept) begin
      if (command_i) begin
        push_o = 1'b1;
      end else if (!halted_q) begin
        if (abort || finish) begin
          len_d  = '0;
          zrun_d = '0;
          num_d  = '0;
          dig_d  = 1'b0;
          head_d = '0;
          aft_d  = '0;
          acnt_d = '0;
          if (abort) begin
            halted_d       = 1'b1;
            push_o         = 1'b1;
            push_ev_o.kind = EV_ABORT;
            push_ev_o.code = 8'd0;
          end else if (len_n != 8'd0) begin
            push_o    = 1'b1;
            push_ev_o = line_ev;
          end
        end else begin
          len_d  = len_n;
          zrun_d = zrun_n;
          num_d  = num_n;
          dig_d  = dig_n;
          head_d = head_n;
          aft_d  = aft_n;
          acnt_d = acnt_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seven_q  <= 1'b0;
      halted_q <= 1'b0;
      len_q    <= '0;
      zrun_q   <= '0;
      num_q    <= '0;
      dig_q    <= 1'b0;
      head_q   <= '0;
      aft_q    <= '0;
      acnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        seven_q <= cfg_wdata_i;
      end
      halted_q <= halted_d;
      len_q    <= len_d;
      zrun_q   <= zrun_d;
      num_q    <= num_d;
      dig_q    <= dig_d;
      head_q   <= head_d;
      aft_q    <= aft_d;
      acnt_q   <= acnt_d;
    end
  end

endmodule

// ----- hw/rtl/ltpc_queue.sv -----
// small fifo of classified events between front and back
`timescale 1ns / 1ps

module ltpc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ltpc_pkg::ev_t push_ev_i,
  output logic          full_o,
  input  logic          pop_i,
  output ltpc_pkg::ev_t pop_ev_o,
  output logic          empty_o
);
  import ltpc_pkg::*;

  ev_t              mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o   = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o  = (cnt_q == '0);
  assign pop_ev_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_ev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/ltpc_back.sv -----
// back end: valid map, done flags and the output register
`timescale 1ns / 1ps

module ltpc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  ltpc_pkg::ev_t ev_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    event_kind_o,
  output logic [7:0]    char_code_o,
  output logic          map_bit_o,
  output logic          both_done_o
);
  import ltpc_pkg::*;

  logic [255:0] map_q;
  logic         remote_q, local_q;
  logic         ovalid_q;
  ev_kind_e     kind_q;
  logic [7:0]   code_q;
  logic         bit_q, both_q;
  logic         remote_n, local_n;

  assign pop_o        = !empty_i && (!ovalid_q || out_ready_i);
  assign out_valid_o  = ovalid_q;
  assign event_kind_o = kind_q;
  assign char_code_o  = code_q;
  assign map_bit_o    = bit_q;
  assign both_done_o  = both_q;

  assign remote_n = remote_q || (ev_i.kind == EV_REMOTE);
  assign local_n  = local_q  || (ev_i.kind == EV_LOCAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q    <= '0;
      remote_q <= 1'b0;
      local_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        ovalid_q <= 1'b1;
        remote_q <= remote_n;
        local_q  <= local_n;
        if (ev_i.kind == EV_VALID) begin
          map_q[ev_i.code] <= 1'b1;
        end
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // payload of the output register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= ev_i.kind;
      code_q <= ev_i.code;
      bit_q  <= (ev_i.kind == EV_MAP_READ) ? map_q[ev_i.code] : 1'b0;
      both_q <= remote_n && local_n;
    end
  end

endmodule

// ----- hw/rtl/line_transparency_packet_checker_unit.sv -----
// Line transparency packet checker: takes one received byte or map-read request per cycle
// on the input stream while the event queue has room, assembles bytes into lines and
// reports one event per finished non-empty line, abort or map read on the output stream.
// Sustained rate is one item per clock while the output accepts; a result is offered once
// the front has classified it and written the event queue at the transfer edge and the
// back end has loaded its output register from that queue. A four-entry event queue
// between front and back absorbs output stalls, so input is refused only when that queue
// is full. The 256-entry valid map is in reset-cleared flip-flops, so no clearing pass is needed.
`timescale 1ns / 1ps

module line_transparency_packet_checker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,   // seven_bit_in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] char_code, [8] map_bit, [9] both_done, zeros
  output logic [2:0]  m_axis_tuser   // [2:0] event_kind
);
  import ltpc_pkg::*;

  logic       push, full, pop, empty;
  ev_t        push_ev, pop_ev;
  logic [7:0] char_code;
  logic       map_bit, both_done;

  ltpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .command_i   (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .push_o      (push),
    .push_ev_o   (push_ev),
    .full_i      (full)
  );

  ltpc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_ev_i (push_ev),
    .full_o    (full),
    .pop_i     (pop),
    .pop_ev_o  (pop_ev),
    .empty_o   (empty)
  );

  ltpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .ev_i         (pop_ev),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .event_kind_o (m_axis_tuser),
    .char_code_o  (char_code),
    .map_bit_o    (map_bit),
    .both_done_o  (both_done)
  );

  assign m_axis_tdata = {6'd0, both_done, map_bit, char_code};

endmodule
